// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define CRE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cre assertion failed");

// Property that must hold in the cycle after its trigger.
`define CRE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cre assertion failed");

`endif

// ----- src/cre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cre_pkg;

  localparam int BOTTOM_BITS = 14;

  localparam logic [31:0] RC_BOT     = 32'(1) << BOTTOM_BITS;
  localparam logic [31:0] RC_TOPMASK = 32'hFF00_0000;
  localparam logic [31:0] RANGE_INIT = 32'hFFFF_FFFF;

  localparam int               CNT_W      = 4;
  localparam logic [CNT_W-1:0] MAX_OUT    = CNT_W'(8);
  localparam logic [CNT_W-1:0] FLUSH_LAST = CNT_W'(3);

  localparam logic        CMD_ENCODE = 1'b0;
  localparam logic        CMD_FLUSH  = 1'b1;

  localparam int          DIV_STEPS  = 32;
  localparam int          DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        cmd;
    logic [13:0] cum_freq;
    logic [14:0] sym_freq;
    logic [14:0] total_freq;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_res_t;

endpackage

`default_nettype wire

// ----- src/carryless_range_encoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Carryless range encoder, 32-bit low bound and range.
// Input channel (in_valid / in_stall / in_item): one command per word, either
// encode one symbol interval or flush. in_stall is high from the cycle after
// acceptance until the sequencer is back in idle.
// Result channel (out_valid / out_stall / out_res): coded bytes, most
// significant first, with last set on the final word of a command; an invalid
// interval gives a single word with error and last set and a zero byte.
// Sequence: an encode runs the bit-serial divider (range divided by total, 32
// quotient steps and the done flag), then the shared multiplier (quotient
// times cum, added to low; quotient times freq, the new range) and the
// interval check, then emits bytes from the top of low, going back to the
// check when the shifted bounds straddle a byte boundary with too small a
// range. A flush emits the top bytes of low, then resets low and range. The
// next command is accepted once the sequencer is back in idle. A stalled
// result word holds; the sequencer waits on it.
// Reset (rst_n low, synchronous) sets low to zero and range to all ones,
// clears the output valid flag and makes the block ready.

module carryless_range_encoder_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cre_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cre_pkg::out_res_t      out_res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_FLUSH,
    S_DIV,
    S_MC,
    S_MF,
    S_MD,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [31:0]               low_bound_r, low_bound_nxt;
  logic [31:0]               range_r, range_nxt;
  logic [31:0]               lo_r, lo_nxt;
  logic [31:0]               hi_r, hi_nxt;
  logic [31:0]               rng_r, rng_nxt;
  logic [13:0]               cum_r, cum_nxt;
  logic [14:0]               frq_r, frq_nxt;
  logic [cre_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  cre_pkg::out_res_t         out_res_r, out_res_nxt;

  logic        accept;
  logic        bad_sym;
  logic [15:0] cum_plus_frq;
  logic        div_start;
  logic        div_done;
  logic [31:0] quo;
  logic [14:0] mul_b;
  logic [31:0] prod;
  logic        out_free;

  logic [31:0] hi_sum;
  logic        sum_diff;
  logic [31:0] lim;
  logic [31:0] up_part;
  logic [31:0] dn_part;
  logic [31:0] lo_sh;
  logic [31:0] hi_sh;
  logic [31:0] rng_sh;
  logic        sh_diff;
  logic [cre_pkg::CNT_W-1:0] cnt_inc;
  logic        last_byte;

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign cum_plus_frq = {2'b00, in_item.cum_freq} + {1'b0, in_item.sym_freq};
  assign bad_sym      = (in_item.sym_freq == '0) || (in_item.total_freq == '0) ||
                        (cum_plus_frq > {1'b0, in_item.total_freq});
  assign div_start    = accept && (in_item.cmd == cre_pkg::CMD_ENCODE) && !bad_sym;
  assign out_free     = !out_valid_r || !out_stall;
  assign mul_b        = (state_r == S_MC) ? {1'b0, cum_r} : frq_r;

  cre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (range_r),
    .divisor  (in_item.total_freq),
    .done     (div_done),
    .quotient (quo)
  );

  cre_mul u_mul (
    .clk  (clk),
    .a    (quo),
    .b    (mul_b),
    .prod (prod)
  );

  // Interval check: the top bytes of low and high differ when any bit of
  // their XOR at or above bit 24 is set.
  assign hi_sum   = lo_r + rng_r;
  assign sum_diff = |((lo_r ^ hi_sum) & cre_pkg::RC_TOPMASK);
  assign lim      = hi_sum & cre_pkg::RC_TOPMASK;
  assign up_part  = hi_sum - lim;
  assign dn_part  = lim - lo_r;

  // Byte shift. A byte is the last one of the command when the count is
  // exhausted, or when the shifted bounds straddle a byte boundary with a
  // range wide enough to end normalization.
  assign lo_sh     = lo_r << 8;
  assign hi_sh     = hi_r << 8;
  assign rng_sh    = hi_sh - lo_sh;
  assign sh_diff   = |((lo_sh ^ hi_sh) & cre_pkg::RC_TOPMASK);
  assign cnt_inc   = cnt_r + 1'b1;
  assign last_byte = (cnt_inc == cre_pkg::MAX_OUT) ||
                     (sh_diff && (rng_sh >= cre_pkg::RC_BOT));

  always_comb begin
    state_nxt     = state_r;
    low_bound_nxt = low_bound_r;
    range_nxt     = range_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    rng_nxt       = rng_r;
    cum_nxt       = cum_r;
    frq_nxt       = frq_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cum_nxt = in_item.cum_freq;
          frq_nxt = in_item.sym_freq;
          cnt_nxt = '0;
          lo_nxt  = low_bound_r;
          if (in_item.cmd == cre_pkg::CMD_FLUSH) begin
            state_nxt = S_FLUSH;
          end else if (bad_sym) begin
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_res_nxt.out_byte = '0;
          out_res_nxt.last     = 1'b1;
          out_res_nxt.error    = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_res_nxt.out_byte = lo_r[31:24];
          out_res_nxt.last     = (cnt_r == cre_pkg::FLUSH_LAST);
          out_res_nxt.error    = 1'b0;
          lo_nxt               = lo_sh;
          cnt_nxt              = cnt_inc;
          if (cnt_r == cre_pkg::FLUSH_LAST) begin
            low_bound_nxt = '0;
            range_nxt     = cre_pkg::RANGE_INIT;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MC;
        end
      end
      S_MC: begin
        state_nxt = S_MF;
      end
      S_MF: begin
        lo_nxt    = low_bound_r + prod;
        state_nxt = S_MD;
      end
      S_MD: begin
        rng_nxt   = prod;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        hi_nxt    = hi_sum;
        state_nxt = S_EMIT;
        if (sum_diff) begin
          if (rng_r > cre_pkg::RC_BOT) begin
            low_bound_nxt = lo_r;
            range_nxt     = rng_r;
            state_nxt     = S_IDLE;
          end else if (up_part >= dn_part) begin
            lo_nxt = lim;
          end else begin
            hi_nxt = lim - 32'd1;
          end
        end
      end
      S_EMIT: begin
        if (cnt_r == cre_pkg::MAX_OUT) begin
          // Range collapsed: stop with whatever bounds are left.
          low_bound_nxt = lo_r;
          range_nxt     = hi_r - lo_r;
          state_nxt     = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_res_nxt.out_byte = lo_r[31:24];
          out_res_nxt.last     = last_byte;
          out_res_nxt.error    = 1'b0;
          lo_nxt               = lo_sh;
          hi_nxt               = hi_sh;
          cnt_nxt              = cnt_inc;
          if (sh_diff) begin
            rng_nxt = rng_sh;
            if (rng_sh >= cre_pkg::RC_BOT) begin
              low_bound_nxt = lo_sh;
              range_nxt     = rng_sh;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_CHECK;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_bound_r <= '0;
      range_r     <= cre_pkg::RANGE_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_bound_r <= low_bound_nxt;
      range_r     <= range_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    rng_r     <= rng_nxt;
    cum_r     <= cum_nxt;
    frq_r     <= frq_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ----- src/cre_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cre_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [14:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [31:0]                   quo_r, quo_nxt;
  logic [14:0]                   rem_r, rem_nxt;
  logic [14:0]                   dvs_r, dvs_nxt;
  logic [cre_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [15:0]                   trial;
  logic [15:0]                   diff;
  logic                          ge;

  // Restoring division: one quotient bit per cycle, MSB first. The
  // dividend bits shift out of quo_r as the quotient bits shift in.
  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = cre_pkg::DIV_CNT_W'(cre_pkg::DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[14:0] : trial[14:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- src/cre_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cre_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [14:0] b,
  output logic [31:0]      prod
);

  logic [46:0] full;
  logic [31:0] prod_r;

  // Only the low 32 bits matter: the coder works modulo 2^32.
  assign full = a * b;

  always_ff @(posedge clk) begin
    prod_r <= full[31:0];
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- src/cre_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cre_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire cre_pkg::in_item_t in_item,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire cre_pkg::out_res_t out_res
);

  logic in_fire;
  logic out_hold;
  logic err_word;
  logic err_ok;

  assign in_fire  = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;
  assign err_word = out_valid && out_res.error;
  assign err_ok   = out_res.last && (out_res.out_byte == 8'd0);

  // A held result word keeps its contents.
  `CRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_res))

  // The block works on one command at a time.
  `CRE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, in_stall)

  // An error word carries no byte and closes its command.
  `CRE_ASSERT_SAME(a_err_word, clk, rst_n, err_word, err_ok)

  // A valid result word is fully defined.
  `CRE_ASSERT_SAME(a_res_known, clk, rst_n, out_valid, !$isunknown(out_res))

endmodule

bind carryless_range_encoder_top cre_checker u_cre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

`default_nettype wire
